/* rtl/crt_pkg.sv */
// Shared types, constants and the timing recompute function for the CRT sync timing core.
package crt_pkg;

    localparam int CHARS_LINE = 128;
    localparam int NUM_REGS = 18;
    localparam int REG_IDX_W = $clog2(NUM_REGS);

    localparam logic [7:0] REG_HDISP = 8'd1;
    localparam logic [7:0] REG_HSYNC_POS = 8'd2;
    localparam logic [7:0] REG_SYNC_WIDTH = 8'd3;
    localparam logic [7:0] REG_VDISP = 8'd6;
    localparam logic [7:0] REG_VSYNC_POS = 8'd7;
    localparam logic [7:0] REG_MAX_RASTER = 8'd9;
    localparam logic [7:0] REG_READ_FIRST = 8'd12;
    localparam logic [7:0] REG_COUNT = 8'(NUM_REGS);

    localparam logic [7:0] WIDE_LIMIT = 8'd40;
    localparam logic [7:0] READ_INVALID = 8'hFF;
    localparam logic [15:0] VSYNC_DEFAULT_WIDTH = 16'd8;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_LINE  = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    typedef struct packed {
        t_req        req_type;
        logic        addr_bit;
        logic [7:0]  write_data;
        logic [15:0] line_number;
        logic [6:0]  char_position;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic       display_on;
        logic       hsync_level;
        logic       vsync_level;
    } t_out_word;

    typedef struct packed {
        logic [8:0]  hs_start;
        logic [9:0]  hs_end;
        logic [15:0] vs_start;
        logic [15:0] vs_end;
        logic [8:0]  de_char;
        logic [15:0] de_line;
    } t_timing;

    typedef struct packed {
        logic display;
        logic hsync;
        logic vsync;
    } t_flags;

    localparam t_timing TIMING_RESET = '{
        hs_start: 9'd94,
        hs_end:   10'd98,
        vs_start: 16'd224,
        vs_end:   16'd227,
        de_char:  9'd80,
        de_line:  16'd200
    };

    localparam t_flags FLAGS_RESET = '{display: 1'b0, hsync: 1'b1, vsync: 1'b1};

    function automatic t_timing timing_calc(
        input logic [7:0] r1,
        input logic [7:0] r2,
        input logic [7:0] r3,
        input logic [7:0] r6,
        input logic [7:0] r7,
        input logic [7:0] r9
    );
        t_timing     t;
        logic        wide;
        logic [8:0]  rows;
        logic [16:0] vs_prod;
        logic [16:0] de_prod;
        logic [3:0]  vwidth;
        wide = r1 > WIDE_LIMIT;
        rows = {1'b0, r9} + 9'd1;
        t.hs_start = wide ? {1'b0, r2} : {r2, 1'b0};
        t.hs_end = {1'b0, t.hs_start} + {6'd0, r3[3:0]};
        vs_prod = {9'd0, r7} * {8'd0, rows};
        t.vs_start = vs_prod[15:0];
        vwidth = r3[7:4];
        t.vs_end = t.vs_start + ((vwidth != 4'd0) ? {12'd0, vwidth} : VSYNC_DEFAULT_WIDTH);
        t.de_char = wide ? {1'b0, r1} : {r1, 1'b0};
        de_prod = {9'd0, r6} * {8'd0, rows};
        t.de_line = de_prod[15:0];
        return t;
    endfunction

endpackage

/* rtl/crt_regs.sv */
// Index/data register file, bus reads and the derived sync timing values.
module crt_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  crt_pkg::t_in_word i_word,
    output logic [7:0]        o_read_data,
    output crt_pkg::t_timing  o_timing
);

    logic [7:0]       r_regs [crt_pkg::NUM_REGS];
    logic [7:0]       n_regs [crt_pkg::NUM_REGS];
    logic [7:0]       r_index;
    logic [7:0]       n_index;
    crt_pkg::t_timing r_timing;
    crt_pkg::t_timing n_timing;
    logic [7:0]       w_rd;

    always_comb begin
        n_regs = r_regs;
        n_index = r_index;
        n_timing = r_timing;
        w_rd = 8'd0;
        if (i_adv) begin
            case (i_word.req_type)
                crt_pkg::REQ_WRITE: begin
                    if (i_word.addr_bit) begin
                        if (r_index < crt_pkg::REG_COUNT) begin
                            n_regs[r_index[crt_pkg::REG_IDX_W-1:0]] = i_word.write_data;
                            n_timing = crt_pkg::timing_calc(
                                n_regs[crt_pkg::REG_HDISP[crt_pkg::REG_IDX_W-1:0]],
                                n_regs[crt_pkg::REG_HSYNC_POS[crt_pkg::REG_IDX_W-1:0]],
                                n_regs[crt_pkg::REG_SYNC_WIDTH[crt_pkg::REG_IDX_W-1:0]],
                                n_regs[crt_pkg::REG_VDISP[crt_pkg::REG_IDX_W-1:0]],
                                n_regs[crt_pkg::REG_VSYNC_POS[crt_pkg::REG_IDX_W-1:0]],
                                n_regs[crt_pkg::REG_MAX_RASTER[crt_pkg::REG_IDX_W-1:0]]);
                        end
                    end else begin
                        n_index = i_word.write_data;
                    end
                end
                crt_pkg::REQ_READ: begin
                    if (i_word.addr_bit) begin
                        if (r_index >= crt_pkg::REG_READ_FIRST && r_index < crt_pkg::REG_COUNT) begin
                            w_rd = r_regs[r_index[crt_pkg::REG_IDX_W-1:0]];
                        end else begin
                            w_rd = crt_pkg::READ_INVALID;
                        end
                    end else begin
                        w_rd = r_index;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < crt_pkg::NUM_REGS; i++) begin
                r_regs[i] <= 8'd0;
            end
            r_index <= 8'd0;
            r_timing <= crt_pkg::TIMING_RESET;
        end else begin
            r_regs <= n_regs;
            r_index <= n_index;
            r_timing <= n_timing;
        end
    end

    assign o_read_data = w_rd;
    assign o_timing = r_timing;

endmodule

/* rtl/crt_sync.sv */
// Display enable, hsync and vsync level tracking for line starts and character ticks.
module crt_sync (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  crt_pkg::t_in_word i_word,
    input  crt_pkg::t_timing  i_timing,
    output crt_pkg::t_flags   o_flags
);

    localparam logic [9:0]  LIMIT_9  = 10'(crt_pkg::CHARS_LINE);
    localparam logic [10:0] LIMIT_10 = 11'(crt_pkg::CHARS_LINE);

    crt_pkg::t_flags r_flags;
    crt_pkg::t_flags n_flags;
    logic            w_de_hit;
    logic            w_hs_on_hit;
    logic            w_hs_off_hit;

    assign w_de_hit = ({1'b0, i_timing.de_char} < LIMIT_9)
                      && ({2'b0, i_word.char_position} == i_timing.de_char);
    assign w_hs_on_hit = ({1'b0, i_timing.hs_start} < LIMIT_9)
                         && ({2'b0, i_word.char_position} == i_timing.hs_start);
    assign w_hs_off_hit = ({1'b0, i_timing.hs_end} < LIMIT_10)
                          && ({3'b0, i_word.char_position} == i_timing.hs_end);

    always_comb begin
        n_flags = r_flags;
        if (i_adv) begin
            case (i_word.req_type)
                crt_pkg::REQ_LINE: begin
                    n_flags.display = i_word.line_number < i_timing.de_line;
                    n_flags.vsync = (i_timing.vs_start <= i_word.line_number)
                                    && (i_word.line_number <= i_timing.vs_end);
                    n_flags.hsync = 1'b0;
                end
                crt_pkg::REQ_TICK: begin
                    if (w_de_hit) begin
                        n_flags.display = 1'b0;
                    end
                    if (w_hs_off_hit) begin
                        n_flags.hsync = 1'b0;
                    end else if (w_hs_on_hit) begin
                        n_flags.hsync = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= crt_pkg::FLAGS_RESET;
        end else begin
            r_flags <= n_flags;
        end
    end

    assign o_flags = n_flags;

    // The end column wins over the start column when both match.
    a_hsync_end_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_word.req_type == crt_pkg::REQ_TICK && w_hs_off_hit |=> !r_flags.hsync)
        else $error("hsync still high after its end column");

endmodule

/* rtl/crt_controller_sync_timing_core.sv */
// Top level of the CRT sync timing core: input register, processing stage, result register.
// A word accepted into the input register is processed and moved into the result register when the output can take it.
// Throughput: one word per cycle while the output is not stalled; the state update of one word is seen by the next.
// The input register and the result register let a word enter while a result waits.
// Reset is synchronous and active low: registers clear to zero, the index to zero, the
// timing values to their power-on defaults, display low and both syncs high.
module crt_controller_sync_timing_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  crt_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output crt_pkg::t_out_word o_out_word
);

    logic               r_in_valid;
    crt_pkg::t_in_word  r_in;
    logic               r_out_valid;
    crt_pkg::t_out_word r_out;
    logic               w_adv;
    logic [7:0]         w_read_data;
    crt_pkg::t_timing   w_timing;
    crt_pkg::t_flags    w_flags;

    assign w_adv = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    crt_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_word      (r_in),
        .o_read_data (w_read_data),
        .o_timing    (w_timing)
    );

    crt_sync u_sync (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_word   (r_in),
        .i_timing (w_timing),
        .o_flags  (w_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (w_adv) begin
            r_out.read_data <= w_read_data;
            r_out.display_on <= w_flags.display;
            r_out.hsync_level <= w_flags.hsync;
            r_out.vsync_level <= w_flags.vsync;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word = r_out;

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in))
        else $error("pending input word lost or changed while stalled");

    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a pending input word");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input not ready with an empty input register");

endmodule
